// File: hw/rtl/bsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types for the bubble sort block: word formats, cell carry, states.
// ----------------------------------------------------------------------------
package bsc_pkg;

  localparam int unsigned ValW = 32;
  localparam int unsigned CmpW = 11;

  typedef struct packed {
    logic signed [ValW-1:0] value;
    logic                   last;
  } in_word_t;

  typedef struct packed {
    logic signed [ValW-1:0] sorted_value;
    logic                   last_out;
    logic [CmpW-1:0]        comparisons;
    logic                   overflowed;
  } out_word_t;

  // element moving right along the chain
  typedef struct packed {
    logic                   vld;
    logic signed [ValW-1:0] value;
  } carry_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SETTLE,
    ST_EMIT
  } state_e;

endpackage

// File: hw/rtl/bsc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_cell
// One sorting cell: keeps the smaller of its element and the arriving one,
// passes the larger to the right; shifts left while the set is read out.
// ----------------------------------------------------------------------------
module bsc_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         shift_i,
  input  bsc_pkg::carry_t              carry_i,
  input  logic                         right_vld_i,
  input  logic signed [bsc_pkg::ValW-1:0] right_val_i,
  output bsc_pkg::carry_t              carry_o,
  output logic                         vld_o,
  output logic signed [bsc_pkg::ValW-1:0] val_o
);
  import bsc_pkg::*;

  logic                   vld_q, vld_d;
  logic signed [ValW-1:0] val_q, val_d;
  carry_t                 carry_q, carry_d;

  always_comb begin
    vld_d   = vld_q;
    val_d   = val_q;
    carry_d = carry_q;
    carry_d.vld = 1'b0;
    if (shift_i) begin
      vld_d = right_vld_i;
      val_d = right_val_i;
    end else if (carry_i.vld) begin
      if (!vld_q) begin
        vld_d = 1'b1;
        val_d = carry_i.value;
      end else if ($signed(carry_i.value) < $signed(val_q)) begin
        val_d   = carry_i.value;
        carry_d = '{vld: 1'b1, value: val_q};
      end else begin
        carry_d = carry_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= 1'b0;
      carry_q <= '0;
    end else begin
      vld_q   <= vld_d;
      carry_q <= carry_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign carry_o = carry_q;
  assign vld_o   = vld_q;
  assign val_o   = val_q;

endmodule

// File: hw/rtl/bubble_sort_with_compare_count.sv
`timescale 1ns / 1ps
// Load: one word per cycle while busy is low; the set closes on last.
// Sort: a chain of MAX_ELEMENTS insertion cells settles after the closing
//   word (busy high).
// Emit: n results back to back, one strobe each; receiver cannot stall.
// Reset: chain empty, count, comparison total and overflow flag cleared.
// ----------------------------------------------------------------------------
// bubble_sort_with_compare_count
// Sorts a set of signed words ascending in a cell chain, then streams it out
// with the comparison count n(n-1)/2 and the overflow flag.
// ----------------------------------------------------------------------------
module bubble_sort_with_compare_count #(
  parameter int unsigned MAX_ELEMENTS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  bsc_pkg::in_word_t  in_word_i,
  output logic               busy,
  output logic               result_valid_o,
  output bsc_pkg::out_word_t result_o
);
  import bsc_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_ELEMENTS + 1);

  state_e state_q, state_d;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] emit_q, emit_d;
  logic [CmpW-1:0] cmp_q, cmp_d;
  logic            ovf_q, ovf_d;
  logic            accept, full, shift;

  carry_t in_q, in_d;

  carry_t                 carry [MAX_ELEMENTS+1];
  logic                   cell_vld [MAX_ELEMENTS+1];
  logic signed [ValW-1:0] cell_val [MAX_ELEMENTS+1];
  logic [MAX_ELEMENTS-1:0] carry_busy;

  logic      res_vld_q, res_vld_d;
  out_word_t res_q, res_d;

  assign accept = start && !busy;
  assign full   = (cnt_q == CntW'(MAX_ELEMENTS));
  assign shift  = (state_q == ST_EMIT);

  // ---------------- cell chain ----------------
  assign carry[0]                 = in_q;
  assign cell_vld[MAX_ELEMENTS]   = 1'b0;
  assign cell_val[MAX_ELEMENTS]   = '0;

  for (genvar g = 0; g < MAX_ELEMENTS; g++) begin : g_cell
    bsc_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .shift_i     (shift),
      .carry_i     (carry[g]),
      .right_vld_i (cell_vld[g+1]),
      .right_val_i (cell_val[g+1]),
      .carry_o     (carry[g+1]),
      .vld_o       (cell_vld[g]),
      .val_o       (cell_val[g])
    );
    assign carry_busy[g] = carry[g+1].vld;
  end

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD:   if (accept && in_word_i.last) state_d = ST_SETTLE;
      ST_SETTLE: if (!in_q.vld && !(|carry_busy)) state_d = ST_EMIT;
      ST_EMIT:   if (emit_q + CntW'(1) == cnt_q) state_d = ST_LOAD;
      default:   state_d = ST_LOAD;
    endcase
  end

  // ---------------- datapath / outputs ----------------
  always_comb begin
    cnt_d     = cnt_q;
    cmp_d     = cmp_q;
    ovf_d     = ovf_q;
    emit_d    = emit_q;
    in_d      = in_q;
    in_d.vld  = 1'b0;
    res_vld_d = 1'b0;
    res_d     = res_q;
    busy      = 1'b1;
    unique case (state_q)
      ST_LOAD: begin
        busy = 1'b0;
        if (accept) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            // running sum 0+1+..+(n-1) gives n(n-1)/2
            cmp_d = cmp_q + CmpW'(cnt_q);
            cnt_d = cnt_q + CntW'(1);
            in_d  = '{vld: 1'b1, value: in_word_i.value};
          end
        end
        emit_d = '0;
      end
      ST_SETTLE: begin
        emit_d = '0;
      end
      ST_EMIT: begin
        res_vld_d          = 1'b1;
        res_d.sorted_value = cell_val[0];
        res_d.last_out     = (emit_q + CntW'(1) == cnt_q);
        res_d.comparisons  = cmp_q;
        res_d.overflowed   = ovf_q;
        emit_d             = emit_q + CntW'(1);
        if (emit_q + CntW'(1) == cnt_q) begin
          cnt_d = '0;
          cmp_d = '0;
          ovf_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      cnt_q     <= '0;
      cmp_q     <= '0;
      ovf_q     <= 1'b0;
      emit_q    <= '0;
      in_q      <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      cmp_q     <= cmp_d;
      ovf_q     <= ovf_d;
      emit_q    <= emit_d;
      in_q      <= in_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

  // ---------------- assertions ----------------
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_ELEMENTS))
    else $error("element count above capacity");

  a_emit_has_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> cell_vld[0])
    else $error("read-out from an empty head cell");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.last_out |=> !result_valid_o)
    else $error("word strobed after final word");

  a_settle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SETTLE |-> !result_valid_o)
    else $error("result strobed while chain settles");

  a_emit_no_carry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> !(|carry_busy) && !in_q.vld)
    else $error("element in flight during read-out");

endmodule
